FILE: src/okle_pkg.sv
`default_nettype none
package okle_pkg;

	// Request codes
	typedef enum logic [2:0] {
		REQ_HEAD_INS = 3'd0,
		REQ_TAIL_INS = 3'd1,
		REQ_POS_INS  = 3'd2,
		REQ_DEL_KEY  = 3'd3,
		REQ_DEL_POS  = 3'd4,
		REQ_COUNT    = 3'd5,
		REQ_FORWARD  = 3'd6,
		REQ_REVERSE  = 3'd7
	} req_t;

	// Result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_MISS  = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_EMPTY = 2'd3;

	typedef enum logic [1:0] {CUR_HOLD, CUR_HEAD, CUR_NXT} cur_sel_t;
	typedef enum logic [1:0] {NRD_CURD, NRD_FREE, NRD_NXT} nrd_sel_t;
	typedef enum logic {KRD_CURD, KRD_STK} krd_sel_t;
	typedef enum logic [1:0] {NWA_CUR, NWA_NODE, NWA_PREV} nwa_sel_t;
	typedef enum logic [1:0] {NWD_NXT, NWD_HEAD, NWD_FREE, NWD_NODE} nwd_sel_t;
	typedef enum logic [1:0] {HEAD_HOLD, HEAD_NODE, HEAD_NXT} head_sel_t;
	typedef enum logic [1:0] {FREE_HOLD, FREE_NXT, FREE_CUR, FREE_NODE} free_sel_t;
	typedef enum logic [1:0] {NODE_HOLD, NODE_FREE, NODE_NXT, NODE_CUR} node_sel_t;
	typedef enum logic [1:0] {PREV_HOLD, PREV_NIL, PREV_CUR} prev_sel_t;
	typedef enum logic [1:0] {CNT_HOLD, CNT_INC, CNT_DEC} cnt_op_t;
	typedef enum logic [1:0] {STEP_HOLD, STEP_LOAD_K, STEP_LOAD_CNT, STEP_DEC} step_op_t;
	typedef enum logic [1:0] {SP_HOLD, SP_CLR, SP_INC, SP_DEC} sp_op_t;
	typedef enum logic [1:0] {K_ZERO, K_CNT, K_POS} k_sel_t;

	typedef struct packed {
		logic      latch;
		k_sel_t    k_sel;
		cur_sel_t  cur_sel;
		nrd_sel_t  nrd_sel;
		krd_sel_t  krd_sel;
		logic      nwr;
		nwa_sel_t  nwa_sel;
		nwd_sel_t  nwd_sel;
		logic      kwr;
		head_sel_t head_sel;
		free_sel_t free_sel;
		node_sel_t node_sel;
		prev_sel_t prev_sel;
		cnt_op_t   cnt_op;
		step_op_t  step_op;
		sp_op_t    sp_op;
		logic      stk_wr;
		logic      stk_rd;
		logic      key_pipe;
		logic      emit;
		logic      emit_key;
		logic      emit_last;
		logic [1:0] emit_status;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic ins_bad;
		logic del_bad;
		logic k_zero;
		logic steps_zero;
		logic steps_one;
		logic match;
		logic prev_nil;
		logic sp_zero;
		logic stk_vld;
		logic key_vld;
	} sts_t;

endpackage
`default_nettype wire

FILE: src/okle_datapath.sv
`default_nettype none
module okle_datapath #(
	parameter int CAPACITY = 32
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  okle_pkg::cmd_t      cmd,
	input  wire signed [31:0]   key_value,
	input  wire        [7:0]    position,
	output okle_pkg::sts_t      sts,
	output logic                strobe,
	output logic        [1:0]   status,
	output logic signed [31:0]  read_key,
	output logic        [6:0]   entry_count,
	output logic                last
);
	import okle_pkg::*;

	localparam int IW = $clog2(CAPACITY + 1);
	localparam int AW = $clog2(CAPACITY);
	localparam logic [IW-1:0] NIL = IW'(CAPACITY);

	logic [IW-1:0] head_q, free_q, count_q, cur_q, prev_q, node_q, steps_q, sp_q;
	logic signed [31:0] key_arg_q;
	logic [7:0] pos_q;

	logic [31:0]   key_mem [CAPACITY];
	logic [IW-1:0] nxt_mem [CAPACITY];
	logic [IW-1:0] stk_mem [CAPACITY];
	logic [CAPACITY-1:0] nvld_q;

	logic [IW-1:0] nrd_q, nrd_adr_q, stk_rd_q;
	logic          nrd_vld_q, stk_vld_q, key_vld_q;
	logic [31:0]   key_rd_q;

	logic [IW-1:0] nxt_data, cur_d, nrd_addr, krd_addr, nwr_addr, nwr_data, sp_m1;
	logic [7:0]    pcl, kk;
	logic [8:0]    cnt_p1;

	function automatic logic position_zero(input logic [7:0] p);
		return p == 8'd0;
	endfunction

	// Entries never written still hold their free-list chaining
	assign nxt_data = nrd_vld_q ? nrd_q : nrd_adr_q + 1'b1;
	assign pcl      = (position_zero(pos_q)) ? 8'd1 : pos_q;
	assign cnt_p1   = 9'(count_q) + 9'd1;
	assign sp_m1    = sp_q - 1'b1;

	always_comb begin
		case (cmd.k_sel)
			K_CNT:   kk = 8'(count_q);
			K_POS:   kk = pcl - 8'd1;
			default: kk = 8'd0;
		endcase
		case (cmd.cur_sel)
			CUR_HEAD: cur_d = head_q;
			CUR_NXT:  cur_d = nxt_data;
			default:  cur_d = cur_q;
		endcase
		case (cmd.nrd_sel)
			NRD_FREE: nrd_addr = free_q;
			NRD_NXT:  nrd_addr = nxt_data;
			default:  nrd_addr = cur_d;
		endcase
		krd_addr = (cmd.krd_sel == KRD_STK) ? stk_rd_q : cur_d;
		case (cmd.nwa_sel)
			NWA_NODE: nwr_addr = node_q;
			NWA_PREV: nwr_addr = prev_q;
			default:  nwr_addr = cur_q;
		endcase
		case (cmd.nwd_sel)
			NWD_HEAD: nwr_data = head_q;
			NWD_FREE: nwr_data = free_q;
			NWD_NODE: nwr_data = node_q;
			default:  nwr_data = nxt_data;
		endcase
	end

	always_comb begin
		sts.full       = count_q == NIL;
		sts.empty      = count_q == '0;
		sts.ins_bad    = {1'b0, pcl} > cnt_p1;
		sts.del_bad    = pcl > 8'(count_q);
		sts.k_zero     = kk == 8'd0;
		sts.steps_zero = steps_q == '0;
		sts.steps_one  = steps_q == IW'(1);
		sts.match      = key_rd_q == key_arg_q;
		sts.prev_nil   = prev_q == NIL;
		sts.sp_zero    = sp_q == '0;
		sts.stk_vld    = stk_vld_q;
		sts.key_vld    = key_vld_q;
	end

	// List registers and control flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= NIL;
			free_q    <= '0;
			count_q   <= '0;
			nvld_q    <= '0;
			stk_vld_q <= 1'b0;
			key_vld_q <= 1'b0;
			strobe    <= 1'b0;
		end else begin
			case (cmd.head_sel)
				HEAD_NODE: head_q <= node_q;
				HEAD_NXT:  head_q <= nxt_data;
				default:   head_q <= head_q;
			endcase
			case (cmd.free_sel)
				FREE_NXT:  free_q <= nxt_data;
				FREE_CUR:  free_q <= cur_q;
				FREE_NODE: free_q <= node_q;
				default:   free_q <= free_q;
			endcase
			case (cmd.cnt_op)
				CNT_INC: count_q <= count_q + 1'b1;
				CNT_DEC: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
			if (cmd.nwr)
				nvld_q[nwr_addr[AW-1:0]] <= 1'b1;
			stk_vld_q <= cmd.stk_rd;
			key_vld_q <= cmd.key_pipe & stk_vld_q;
			strobe    <= cmd.emit;
		end
	end

	// Walk registers, memories and result payload
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			key_arg_q <= key_value;
			pos_q     <= position;
		end
		cur_q <= cur_d;
		case (cmd.prev_sel)
			PREV_NIL: prev_q <= NIL;
			PREV_CUR: prev_q <= cur_q;
			default:  prev_q <= prev_q;
		endcase
		case (cmd.node_sel)
			NODE_FREE: node_q <= free_q;
			NODE_NXT:  node_q <= nxt_data;
			NODE_CUR:  node_q <= cur_q;
			default:   node_q <= node_q;
		endcase
		case (cmd.step_op)
			STEP_LOAD_K:   steps_q <= IW'(kk - 8'd1);
			STEP_LOAD_CNT: steps_q <= count_q;
			STEP_DEC:      steps_q <= steps_q - 1'b1;
			default:       steps_q <= steps_q;
		endcase
		case (cmd.sp_op)
			SP_CLR:  sp_q <= '0;
			SP_INC:  sp_q <= sp_q + 1'b1;
			SP_DEC:  sp_q <= sp_m1;
			default: sp_q <= sp_q;
		endcase

		if (cmd.nwr)
			nxt_mem[nwr_addr[AW-1:0]] <= nwr_data;
		nrd_q     <= nxt_mem[nrd_addr[AW-1:0]];
		nrd_vld_q <= nvld_q[nrd_addr[AW-1:0]];
		nrd_adr_q <= nrd_addr;

		if (cmd.kwr)
			key_mem[node_q[AW-1:0]] <= key_arg_q;
		key_rd_q <= key_mem[krd_addr[AW-1:0]];

		if (cmd.stk_wr)
			stk_mem[sp_q[AW-1:0]] <= cur_q;
		stk_rd_q <= stk_mem[sp_m1[AW-1:0]];

		if (cmd.emit) begin
			status      <= cmd.emit_status;
			read_key    <= cmd.emit_key ? key_rd_q : 32'sd0;
			entry_count <= 7'(count_q);
			last        <= cmd.emit_last;
		end
	end

endmodule
`default_nettype wire

FILE: src/okle_ctrl.sv
`default_nettype none
module okle_ctrl (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            start,
	input  wire [2:0]      req_type,
	input  okle_pkg::sts_t sts,
	output okle_pkg::cmd_t cmd,
	output logic           busy
);
	import okle_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_DISPATCH, S_INS_A, S_WALK, S_INS_L2, S_DEL_B, S_DEL_C,
		S_DEL_HEAD, S_KEY, S_FWD, S_PUSH, S_POP, S_REPORT
	} state_t;

	state_t     state_q, state_d;
	req_t       req_q;
	logic [1:0] stat_q, stat_d;

	assign busy = state_q != S_IDLE;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		stat_d  = stat_q;
		unique case (req_q)
			REQ_HEAD_INS: cmd.k_sel = K_ZERO;
			REQ_TAIL_INS: cmd.k_sel = K_CNT;
			default:      cmd.k_sel = K_POS;
		endcase
		unique case (state_q)
			S_IDLE: begin
				cmd.latch = start;
				if (start)
					state_d = S_DISPATCH;
			end
			S_DISPATCH: begin
				unique case (req_q) inside
					REQ_HEAD_INS, REQ_TAIL_INS, REQ_POS_INS: begin
						if (sts.full) begin
							stat_d  = ST_FULL;
							state_d = S_REPORT;
						end else if (req_q == REQ_POS_INS && sts.ins_bad) begin
							stat_d  = ST_MISS;
							state_d = S_REPORT;
						end else begin
							cmd.node_sel = NODE_FREE;
							cmd.nrd_sel  = NRD_FREE;
							cmd.cur_sel  = CUR_HEAD;
							cmd.step_op  = STEP_LOAD_K;
							state_d      = S_INS_A;
						end
					end
					REQ_DEL_POS: begin
						if (sts.del_bad) begin
							stat_d  = ST_MISS;
							state_d = S_REPORT;
						end else begin
							cmd.cur_sel = CUR_HEAD;
							cmd.step_op = STEP_LOAD_K;
							state_d     = sts.k_zero ? S_DEL_HEAD : S_WALK;
						end
					end
					REQ_DEL_KEY: begin
						if (sts.empty) begin
							stat_d  = ST_MISS;
							state_d = S_REPORT;
						end else begin
							cmd.cur_sel  = CUR_HEAD;
							cmd.step_op  = STEP_LOAD_CNT;
							cmd.prev_sel = PREV_NIL;
							state_d      = S_KEY;
						end
					end
					REQ_COUNT: begin
						stat_d  = ST_OK;
						state_d = S_REPORT;
					end
					default: begin
						if (sts.empty) begin
							stat_d  = ST_EMPTY;
							state_d = S_REPORT;
						end else begin
							cmd.cur_sel = CUR_HEAD;
							cmd.step_op = STEP_LOAD_CNT;
							cmd.sp_op   = SP_CLR;
							state_d     = (req_q == REQ_FORWARD) ? S_FWD : S_PUSH;
						end
					end
				endcase
			end
			S_INS_A: begin
				cmd.free_sel = FREE_NXT;
				cmd.kwr      = 1'b1;
				if (sts.k_zero) begin
					cmd.nwr      = 1'b1;
					cmd.nwa_sel  = NWA_NODE;
					cmd.nwd_sel  = NWD_HEAD;
					cmd.head_sel = HEAD_NODE;
					cmd.cnt_op   = CNT_INC;
					stat_d       = ST_OK;
					state_d      = S_REPORT;
				end else begin
					state_d = S_WALK;
				end
			end
			S_WALK: begin
				if (!sts.steps_zero) begin
					cmd.cur_sel = CUR_NXT;
					cmd.step_op = STEP_DEC;
				end else if (req_q == REQ_DEL_POS) begin
					cmd.node_sel = NODE_NXT;
					cmd.nrd_sel  = NRD_NXT;
					state_d      = S_DEL_B;
				end else begin
					cmd.nwr     = 1'b1;
					cmd.nwa_sel = NWA_NODE;
					cmd.nwd_sel = NWD_NXT;
					state_d     = S_INS_L2;
				end
			end
			S_INS_L2: begin
				cmd.nwr     = 1'b1;
				cmd.nwa_sel = NWA_CUR;
				cmd.nwd_sel = NWD_NODE;
				cmd.cnt_op  = CNT_INC;
				stat_d      = ST_OK;
				state_d     = S_REPORT;
			end
			S_DEL_B: begin
				cmd.nwr     = 1'b1;
				cmd.nwa_sel = NWA_CUR;
				cmd.nwd_sel = NWD_NXT;
				state_d     = S_DEL_C;
			end
			S_DEL_C: begin
				cmd.nwr      = 1'b1;
				cmd.nwa_sel  = NWA_NODE;
				cmd.nwd_sel  = NWD_FREE;
				cmd.free_sel = FREE_NODE;
				cmd.cnt_op   = CNT_DEC;
				stat_d       = ST_OK;
				state_d      = S_REPORT;
			end
			S_DEL_HEAD: begin
				cmd.head_sel = HEAD_NXT;
				cmd.nwr      = 1'b1;
				cmd.nwa_sel  = NWA_CUR;
				cmd.nwd_sel  = NWD_FREE;
				cmd.free_sel = FREE_CUR;
				cmd.cnt_op   = CNT_DEC;
				stat_d       = ST_OK;
				state_d      = S_REPORT;
			end
			S_KEY: begin
				if (sts.match && sts.prev_nil) begin
					cmd.head_sel = HEAD_NXT;
					cmd.nwr      = 1'b1;
					cmd.nwa_sel  = NWA_CUR;
					cmd.nwd_sel  = NWD_FREE;
					cmd.free_sel = FREE_CUR;
					cmd.cnt_op   = CNT_DEC;
					stat_d       = ST_OK;
					state_d      = S_REPORT;
				end else if (sts.match) begin
					cmd.nwr      = 1'b1;
					cmd.nwa_sel  = NWA_PREV;
					cmd.nwd_sel  = NWD_NXT;
					cmd.node_sel = NODE_CUR;
					state_d      = S_DEL_C;
				end else if (sts.steps_one) begin
					stat_d  = ST_MISS;
					state_d = S_REPORT;
				end else begin
					cmd.prev_sel = PREV_CUR;
					cmd.cur_sel  = CUR_NXT;
					cmd.step_op  = STEP_DEC;
				end
			end
			S_FWD: begin
				cmd.emit        = 1'b1;
				cmd.emit_key    = 1'b1;
				cmd.emit_last   = sts.steps_one;
				cmd.emit_status = ST_OK;
				if (sts.steps_one) begin
					state_d = S_IDLE;
				end else begin
					cmd.cur_sel = CUR_NXT;
					cmd.step_op = STEP_DEC;
				end
			end
			S_PUSH: begin
				cmd.stk_wr = 1'b1;
				cmd.sp_op  = SP_INC;
				if (sts.steps_one) begin
					state_d = S_POP;
				end else begin
					cmd.cur_sel = CUR_NXT;
					cmd.step_op = STEP_DEC;
				end
			end
			S_POP: begin
				cmd.krd_sel     = KRD_STK;
				cmd.key_pipe    = 1'b1;
				cmd.stk_rd      = !sts.sp_zero;
				cmd.sp_op       = sts.sp_zero ? SP_HOLD : SP_DEC;
				cmd.emit        = sts.key_vld;
				cmd.emit_key    = 1'b1;
				cmd.emit_last   = !sts.stk_vld && sts.sp_zero;
				cmd.emit_status = ST_OK;
				if (sts.key_vld && !sts.stk_vld && sts.sp_zero)
					state_d = S_IDLE;
			end
			S_REPORT: begin
				cmd.emit        = 1'b1;
				cmd.emit_last   = 1'b1;
				cmd.emit_status = stat_q;
				state_d         = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			req_q   <= REQ_COUNT;
			stat_q  <= ST_OK;
		end else begin
			state_q <= state_d;
			stat_q  <= stat_d;
			if (state_q == S_IDLE && start)
				req_q <= req_t'(req_type);
		end
	end

endmodule
`default_nettype wire

FILE: src/ordered_key_list_engine_unit.sv
`default_nettype none
// Ordered key list engine: a bounded singly linked list of up to CAPACITY signed
// 32-bit keys, chained through a next-index memory with a free list. Raise start
// with a request while busy is low; the word is taken at that edge and busy stays
// high until the request is done. Results come out one word per cycle on strobe
// and cannot be held off: a read-out of a non-empty list gives one word per key,
// back to back, with last on the final one; every other request, and a read-out
// of an empty list, gives a single word with last set. Requests that walk the
// list use a one-step-per-cycle chain walk through the next-index memory, whose
// registered read feeds the next address. Positional inserts and deletes past
// the head walk to the entry before the target, delete by key walks until a
// match or the last entry, and reverse read-out walks once to fill an index
// stack and then drains it. Busy falls as the final word appears, so a new
// request may be taken at the edge that ends that word's cycle.
module ordered_key_list_engine_unit #(
	parameter int CAPACITY = 32
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	output logic               busy,
	input  wire        [2:0]   req_type,
	input  wire signed [31:0]  key_value,
	input  wire        [7:0]   position,
	output logic               strobe,
	output logic       [1:0]   status,
	output logic signed [31:0] read_key,
	output logic       [6:0]   entry_count,
	output logic               last
);
	import okle_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// Sequence each request
	okle_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req_type),
		.sts      (sts),
		.cmd      (cmd),
		.busy     (busy)
	);

	// Hold list memories, walk pointers and the result register
	okle_datapath #(.CAPACITY(CAPACITY)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.key_value   (key_value),
		.position    (position),
		.sts         (sts),
		.strobe      (strobe),
		.status      (status),
		.read_key    (read_key),
		.entry_count (entry_count),
		.last        (last)
	);

endmodule
`default_nettype wire

FILE: src/okle_checker.sv
`default_nettype none
module okle_checker #(
	parameter int CAPACITY = 32
) (
	input wire               clk,
	input wire               arst_n,
	input wire               start,
	input wire               busy,
	input wire        [2:0]  req_type,
	input wire signed [31:0] key_value,
	input wire        [7:0]  position,
	input wire               strobe,
	input wire        [1:0]  status,
	input wire signed [31:0] read_key,
	input wire        [6:0]  entry_count,
	input wire               last
);
	import okle_pkg::*;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> entry_count <= 7'(CAPACITY))
		else $error("entry count above capacity");

	a_readout_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> strobe)
		else $error("read-out words not back to back");

	a_error_single: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && status != ST_OK |-> last)
		else $error("error status on a non-final word");

	a_empty_word: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && status == ST_EMPTY |-> read_key == 32'sd0 && entry_count == 7'd0)
		else $error("empty read-out word malformed");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after accept");

endmodule

bind ordered_key_list_engine_unit okle_checker #(.CAPACITY(CAPACITY)) u_okle_checker (.*);
`default_nettype wire

FILE: tb/sv/tb_top.sv
`default_nettype none
module tb_top;
	import okle_pkg::*;

	localparam int CAPACITY = 32;
	localparam int N_RANDOM = 410;
	localparam int CALM_TAIL = 60;        // last random words go with no idling
	localparam int CYCLE_LIMIT = 600000;

	// One result word as it leaves the block
	typedef struct packed {
		logic [1:0]         st;
		logic signed [31:0] key;
		logic [6:0]         cnt;
		logic               lst;
	} word_t;

	// One row of the directed table; typed rows carry the expected word
	typedef struct {
		req_t               req;
		logic signed [31:0] key;
		logic [7:0]         pos;
		bit                 typed;
		word_t              exp_word;
	} row_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [2:0]         req_type;
	logic signed [31:0] key_value;
	logic [7:0]         position;
	logic               strobe;
	logic [1:0]         status;
	logic signed [31:0] read_key;
	logic [6:0]         entry_count;
	logic               last;

	logic signed [31:0] list_keys[$];     // shadow of the list, head first
	word_t              pending_words[$]; // words the block still owes
	int                 fail_count;
	int                 cycles;
	bit                 calm;
	row_t               rows[$];

	ordered_key_list_engine_unit #(.CAPACITY(CAPACITY)) i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req_type(req_type), .key_value(key_value), .position(position),
		.strobe(strobe), .status(status), .read_key(read_key),
		.entry_count(entry_count), .last(last)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Hard stop in case the block hangs
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("MISMATCH %s: got %0h expected %0h (cycle %0d)", what, got, want, cycles);
		fail_count++;
	endtask

	function automatic word_t mk_word(logic [1:0] st, logic signed [31:0] key, int cnt,
			logic lst);
		word_t w;
		w.st = st;
		w.key = key;
		w.cnt = cnt[6:0];
		w.lst = lst;
		return w;
	endfunction

	// Apply one request to the shadow list and queue the words it causes
	function automatic void list_step(req_t req, logic signed [31:0] key, logic [7:0] pos,
			bit push);
		int p;
		int n;
		int hit;
		logic [1:0] st;
		p = (pos < 1) ? 1 : pos;
		st = ST_OK;
		case (req)
			REQ_HEAD_INS, REQ_TAIL_INS, REQ_POS_INS: begin
				// full check wins over the position check
				if (list_keys.size() >= CAPACITY) st = ST_FULL;
				else if (req == REQ_HEAD_INS) list_keys.push_front(key);
				else if (req == REQ_TAIL_INS) list_keys.push_back(key);
				else if (p > list_keys.size() + 1) st = ST_MISS;
				else list_keys.insert(p - 1, key);
			end
			REQ_DEL_KEY: begin
				hit = -1;
				foreach (list_keys[i])
					if (hit < 0 && list_keys[i] == key) hit = i;
				if (hit < 0) st = ST_MISS;
				else list_keys.delete(hit);
			end
			REQ_DEL_POS: begin
				if (p > list_keys.size()) st = ST_MISS;
				else list_keys.delete(p - 1);
			end
			REQ_COUNT: ;
			default: begin
				n = list_keys.size();
				if (n == 0) begin
					if (push) pending_words.push_back(mk_word(ST_EMPTY, 0, 0, 1'b1));
				end else if (push) begin
					for (int i = 0; i < n; i++)
						pending_words.push_back(mk_word(ST_OK,
							list_keys[(req == REQ_FORWARD) ? i : n - 1 - i], n, i == n - 1));
				end
				return;
			end
		endcase
		if (push) pending_words.push_back(mk_word(st, 0, list_keys.size(), 1'b1));
	endfunction

	// Present one word and hold it until the block takes it
	task automatic issue(input req_t req, input logic signed [31:0] key, input logic [7:0] pos,
			input bit predicted, input word_t typed_word);
		int gap;
		@(negedge clk);
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 8);
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		start = 1'b1;
		req_type = req;
		key_value = key;
		position = pos;
		do @(posedge clk); while (busy !== 1'b0);
		// accepted at this edge: predict now, before the first result can show
		list_step(req, key, pos, predicted);
		if (!predicted) pending_words.push_back(typed_word);
	endtask

	// Check every result word against the oldest expectation
	always @(posedge clk) begin
		word_t w;
		if (arst_n && strobe === 1'b1) begin
			if (pending_words.size() == 0) begin
				report("unexpected word", {30'd0, status}, 0);
			end else begin
				w = pending_words.pop_front();
				if (status !== w.st) report("status", 32'(status), 32'(w.st));
				if (read_key !== w.key) report("read_key", read_key, w.key);
				if (entry_count !== w.cnt)
					report("entry_count", 32'(entry_count), 32'(w.cnt));
				if (last !== w.lst) report("last", 32'(last), 32'(w.lst));
			end
		end
	end

	function automatic void add_row(req_t req, logic signed [31:0] key, int pos, bit typed,
			logic [1:0] st, int cnt);
		row_t r;
		r.req = req;
		r.key = key;
		r.pos = pos[7:0];
		r.typed = typed;
		r.exp_word = mk_word(st, 0, cnt, 1'b1);
		rows.push_back(r);
	endfunction

	// Pick a key: mostly from a small pool or the list itself so deletes hit
	function automatic logic signed [31:0] pick_key();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 3 && list_keys.size() > 0)
			return list_keys[$urandom_range(0, list_keys.size() - 1)];
		if (sel < 7) return $signed($urandom_range(0, 7)) - 4;
		return $urandom();
	endfunction

	function automatic logic [7:0] pick_pos();
		if ($urandom_range(0, 7) == 0) return 8'($urandom_range(0, 255));
		return 8'($urandom_range(0, list_keys.size() + 2));
	endfunction

	initial begin
		int mode;
		int roll;
		req_t req;
		word_t none;
		fail_count = 0;
		cycles = 0;
		calm = 1'b0;
		none = '0;
		arst_n = 1'b0;
		start = 1'b0;
		req_type = REQ_COUNT;
		key_value = 0;
		position = 0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// directed: empty-list cases, extremes of key and position, every request
		add_row(REQ_COUNT, 0, 0, 1, ST_OK, 0);
		add_row(REQ_FORWARD, 0, 0, 1, ST_EMPTY, 0);
		add_row(REQ_REVERSE, 0, 0, 1, ST_EMPTY, 0);
		add_row(REQ_DEL_KEY, 5, 0, 1, ST_MISS, 0);
		add_row(REQ_DEL_POS, 0, 0, 1, ST_MISS, 0);
		add_row(REQ_POS_INS, 1, 2, 1, ST_MISS, 0);
		add_row(REQ_POS_INS, 32'sh8000_0000, 0, 1, ST_OK, 1);
		add_row(REQ_HEAD_INS, 32'sh7fff_ffff, 0, 1, ST_OK, 2);
		add_row(REQ_TAIL_INS, -1, 255, 1, ST_OK, 3);
		add_row(REQ_POS_INS, 0, 4, 1, ST_OK, 4);
		add_row(REQ_POS_INS, 9, 255, 1, ST_MISS, 4);
		add_row(REQ_POS_INS, 32'sh5a5a_a5a5, 2, 0, ST_OK, 0);
		add_row(REQ_FORWARD, 0, 0, 0, ST_OK, 0);
		add_row(REQ_REVERSE, 0, 0, 0, ST_OK, 0);
		add_row(REQ_DEL_KEY, 32'sh7fff_ffff, 0, 1, ST_OK, 4);
		add_row(REQ_DEL_KEY, 12345, 0, 1, ST_MISS, 4);
		add_row(REQ_DEL_POS, 0, 255, 1, ST_MISS, 4);
		add_row(REQ_DEL_POS, 0, 4, 1, ST_OK, 3);
		add_row(REQ_DEL_POS, 0, 0, 1, ST_OK, 2);
		add_row(REQ_COUNT, 0, 0, 1, ST_OK, 2);
		add_row(REQ_FORWARD, 0, 0, 0, ST_OK, 0);
		add_row(REQ_REVERSE, 0, 0, 0, ST_OK, 0);
		foreach (rows[i])
			issue(rows[i].req, rows[i].key, rows[i].pos, !rows[i].typed, rows[i].exp_word);

		// random: swing between filling to full and draining to empty
		mode = 0;
		for (int n = 0; n < N_RANDOM; n++) begin
			calm = (n >= N_RANDOM - CALM_TAIL);
			if (list_keys.size() >= CAPACITY && $urandom_range(0, 3) == 0) mode = 1;
			else if (list_keys.size() == 0 && $urandom_range(0, 1) == 0) mode = 0;
			else if ($urandom_range(0, 39) == 0) mode = $urandom_range(0, 2);
			roll = $urandom_range(0, 99);
			if (mode == 0)
				req = (roll < 70) ? req_t'($urandom_range(0, 2)) : req_t'($urandom_range(3, 7));
			else if (mode == 1)
				req = (roll < 70) ? req_t'($urandom_range(3, 4)) : req_t'($urandom_range(0, 7));
			else
				req = req_t'($urandom_range(0, 7));
			issue(req, pick_key(), pick_pos(), 1'b1, none);
		end

		@(negedge clk);
		start = 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
		repeat (4 * CAPACITY + 8) @(posedge clk);
		if (fail_count == 0 && pending_words.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
`default_nettype wire
